[design/ibq_pkg.sv]
// Shared types and constants for the biquad filter with output limits.
// No dependencies; imported by every module of the block.
package ibq_pkg;

  localparam int SAMPLE_W            = 16;
  localparam int COEFF_W             = 18;
  localparam int STEP_W              = 16;
  localparam int COEFF_FRAC_BITS_DEF = 14;
  localparam int CFG_W               = 18;
  localparam int CFG_ADDR_W          = 3;
  localparam int MUL_B_W             = ((SAMPLE_W > STEP_W) ? SAMPLE_W : STEP_W) + 1;
  localparam int PROD_W              = COEFF_W + MUL_B_W;
  localparam int ACC_W               = PROD_W + 3;
  localparam int MAC_TAPS            = 5;

  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam logic [1:0] CMD_FILTER  = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_PRE_IN  = 2'd2;
  localparam logic [1:0] CMD_PRE_OUT = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_B0       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_B1       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_B2       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_A1       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_A2       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LIM_LO   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LIM_HI   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_RAMP_LEN = 3'd7;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [SAMPLE_W-1:0] sample;
  } ibq_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } ibq_out_t;

endpackage

[design/iir_biquad_with_saturation.sv]
// Direct-form-I biquad with rounding, soft-start ramped limits and output clamp.
// Depends on ibq_pkg. One shared multiplier and a radix-2 divider under a sequencer.
// While soft start is active, the result also takes two 16-step divisions. One word at a time:
// the next word is taken only after the result registers and the sequencer returns to
// idle; a stalled result holds the sequencer in its output state. Reset (synchronous,
// rst_n low): registers take their defaults, history and counter clear.
module iir_biquad_with_saturation #(
  parameter int COEFF_FRAC_BITS = ibq_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ibq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ibq_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ibq_pkg::ibq_in_t               in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ibq_pkg::ibq_out_t              out_word
);
  import ibq_pkg::*;

  localparam int CNT_W = $clog2(STEP_W);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MAC    = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_RMUL   = 3'd3;
  localparam logic [2:0] ST_RLOAD  = 3'd4;
  localparam logic [2:0] ST_RDIV   = 3'd5;
  localparam logic [2:0] ST_RCLAMP = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  localparam logic signed [COEFF_W-1:0] B0_RST = COEFF_W'(64'sd1 <<< COEFF_FRAC_BITS);
  localparam logic signed [ACC_W-1:0]   RND    = ACC_W'(1) << (COEFF_FRAC_BITS - 1);

  logic signed [COEFF_W-1:0]  b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SAMPLE_W-1:0] lim_lo_r, lim_hi_r;
  logic [STEP_W-1:0]          ramp_len_r;

  logic signed [SAMPLE_W-1:0] xh0_r, xh1_r, yh0_r, yh1_r;
  logic [STEP_W-1:0]          step_r;
  logic                       sat_r;

  logic [2:0]                 state_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       sel_lo_r;
  logic                       sub_r;
  logic                       out_valid_r;

  logic [1:0]                 cmd_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic                       neg_r;
  logic [STEP_W-1:0]          rem_r, quo_r;
  ibq_out_t                   out_word_r;

  logic signed [COEFF_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [ACC_W-1:0]    rnd_sum, rnd_shr;
  logic signed [SAMPLE_W-1:0] y_rnd;
  logic                       ramp_act;
  logic signed [PROD_W-1:0]   mag;
  logic [STEP_W+1:0]          trial;
  logic                       ge;
  logic signed [SAMPLE_W-1:0] q_s, ramp_lim;
  logic signed [SAMPLE_W-1:0] res_y;
  logic                       sat_nxt;
  logic                       out_fire;
  logic                       in_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_fire  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r       <= B0_RST;
      b1_r       <= '0;
      b2_r       <= '0;
      a1_r       <= '0;
      a2_r       <= '0;
      lim_lo_r   <= SMIN;
      lim_hi_r   <= SMAX;
      ramp_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_B0:       b0_r       <= cfg_wdata[COEFF_W-1:0];
        REG_B1:       b1_r       <= cfg_wdata[COEFF_W-1:0];
        REG_B2:       b2_r       <= cfg_wdata[COEFF_W-1:0];
        REG_A1:       a1_r       <= cfg_wdata[COEFF_W-1:0];
        REG_A2:       a2_r       <= cfg_wdata[COEFF_W-1:0];
        REG_LIM_LO:   lim_lo_r   <= cfg_wdata[SAMPLE_W-1:0];
        REG_LIM_HI:   lim_hi_r   <= cfg_wdata[SAMPLE_W-1:0];
        REG_RAMP_LEN: ramp_len_r <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_RMUL) begin
      mul_a = COEFF_W'(sel_lo_r ? lim_lo_r : lim_hi_r);
      mul_b = MUL_B_W'({1'b0, step_r});
    end else begin
      case (cnt_r)
        CNT_W'(0): begin mul_a = b0_r; mul_b = MUL_B_W'(x_r);   end
        CNT_W'(1): begin mul_a = b1_r; mul_b = MUL_B_W'(xh0_r); end
        CNT_W'(2): begin mul_a = b2_r; mul_b = MUL_B_W'(xh1_r); end
        CNT_W'(3): begin mul_a = a1_r; mul_b = MUL_B_W'(yh0_r); end
        CNT_W'(4): begin mul_a = a2_r; mul_b = MUL_B_W'(yh1_r); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  assign rnd_sum  = acc_r + RND;
  assign rnd_shr  = rnd_sum >>> COEFF_FRAC_BITS;
  assign y_rnd    = (rnd_shr > ACC_W'(SMAX)) ? SMAX :
                    (rnd_shr < ACC_W'(SMIN)) ? SMIN : rnd_shr[SAMPLE_W-1:0];
  assign ramp_act = (ramp_len_r != '0) && (step_r < ramp_len_r);

  assign mag      = prod_r[PROD_W-1] ? -prod_r : prod_r;
  assign trial    = {1'b0, rem_r, quo_r[STEP_W-1]} - {2'b00, ramp_len_r};
  assign ge       = !trial[STEP_W+1];
  assign q_s      = SAMPLE_W'(quo_r);
  assign ramp_lim = neg_r ? -q_s : q_s;

  always_comb begin
    res_y   = y_r;
    sat_nxt = sat_r;
    case (cmd_r)
      CMD_FILTER: begin
        if (y_r > lim_hi_r) begin
          res_y   = lim_hi_r;
          sat_nxt = 1'b1;
        end else if (y_r < lim_lo_r) begin
          res_y   = lim_lo_r;
          sat_nxt = 1'b1;
        end else begin
          res_y   = y_r;
          sat_nxt = 1'b0;
        end
      end
      CMD_CLEAR:   res_y = '0;
      CMD_PRE_IN:  res_y = yh0_r;
      CMD_PRE_OUT: res_y = x_r;
      default:     res_y = y_r;
    endcase
  end

  // sequencer, history and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_lo_r    <= 1'b0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
      xh0_r       <= '0;
      xh1_r       <= '0;
      yh0_r       <= '0;
      yh1_r       <= '0;
      step_r      <= '0;
      sat_r       <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_r    <= '0;
            sel_lo_r <= 1'b0;
            state_r  <= (in_word.command == CMD_FILTER) ? ST_MAC : ST_OUT;
          end
        end
        ST_MAC: begin
          sub_r <= (cnt_r >= CNT_W'(3));
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(MAC_TAPS)) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          state_r <= ramp_act ? ST_RMUL : ST_OUT;
        end
        ST_RMUL: begin
          state_r <= ST_RLOAD;
        end
        ST_RLOAD: begin
          cnt_r   <= '0;
          state_r <= ST_RDIV;
        end
        ST_RDIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STEP_W - 1)) begin
            state_r <= ST_RCLAMP;
          end
        end
        ST_RCLAMP: begin
          sel_lo_r <= 1'b1;
          state_r  <= sel_lo_r ? ST_OUT : ST_RMUL;
        end
        ST_OUT: begin
          if (out_fire) begin
            out_valid_r <= 1'b1;
            sat_r       <= sat_nxt;
            state_r     <= ST_IDLE;
            case (cmd_r)
              CMD_FILTER: begin
                xh1_r <= xh0_r;
                xh0_r <= x_r;
                yh1_r <= yh0_r;
                yh0_r <= res_y;
                if (step_r != '1) begin
                  step_r <= step_r + 1'b1;
                end
              end
              CMD_CLEAR: begin
                xh0_r  <= '0;
                xh1_r  <= '0;
                yh0_r  <= '0;
                yh1_r  <= '0;
                step_r <= '0;
              end
              CMD_PRE_IN: begin
                xh0_r <= x_r;
                xh1_r <= x_r;
              end
              CMD_PRE_OUT: begin
                yh0_r <= x_r;
                yh1_r <= x_r;
              end
              default: ;
            endcase
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_r <= in_word.command;
          x_r   <= in_word.sample;
          acc_r <= '0;
        end
      end
      ST_MAC: begin
        if (cnt_r < CNT_W'(MAC_TAPS)) begin
          prod_r <= mul_p;
        end
        if (cnt_r != '0) begin
          acc_r <= sub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        end
      end
      ST_ROUND: y_r <= y_rnd;
      ST_RMUL:  prod_r <= mul_p;
      ST_RLOAD: begin
        neg_r <= prod_r[PROD_W-1];
        rem_r <= mag[2*STEP_W-1:STEP_W];
        quo_r <= mag[STEP_W-1:0];
      end
      ST_RDIV: begin
        rem_r <= ge ? trial[STEP_W-1:0] : {rem_r[STEP_W-2:0], quo_r[STEP_W-1]};
        quo_r <= {quo_r[STEP_W-2:0], ge};
      end
      ST_RCLAMP: begin
        if (!sel_lo_r && (y_r > ramp_lim)) begin
          y_r <= ramp_lim;
        end else if (sel_lo_r && (y_r < ramp_lim)) begin
          y_r <= ramp_lim;
        end
      end
      ST_OUT: begin
        if (out_fire) begin
          out_word_r.filtered  <= res_y;
          out_word_r.saturated <= sat_nxt;
        end
      end
      default: ;
    endcase
  end

endmodule

[design/ibq_checker.sv]
// Port-level checks on the biquad filter's word handshakes.
// Depends on ibq_pkg; bound to iir_biquad_with_saturation below.
module ibq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ibq_pkg::ibq_in_t  in_word,
  input logic              out_valid,
  input logic              out_ready,
  input ibq_pkg::ibq_out_t out_word
);
  import ibq_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again while a word is in progress");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared without a word in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word dropped or changed");

endmodule

bind iir_biquad_with_saturation ibq_checker u_ibq_checker (.*);
